// ----- rtl/crrc_pkg.sv -----
// shared types and constants for the command ring reserve/commit unit
// no dependencies; used by the interfaces, imported by crrc_eval and the top level
`timescale 1ns / 1ps

package crrc_pkg;

  localparam int PTR_W        = 23;
  localparam int CNT_W        = 17;
  localparam int OP_W         = 2;
  localparam int ST_W         = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 23;
  // signed working width for the free-space and fit tests
  localparam int SW           = PTR_W + 3;
  localparam int BOUNCE_BYTES = 65536;

  localparam logic [PTR_W-1:0] RING_LOW_RST  = '0;
  localparam logic [PTR_W-1:0] RING_HIGH_RST = PTR_W'(4194304);

  localparam logic [CFG_IDX_W-1:0] CFG_RING_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_CAP   = 2'd2;

  // spare opcode is consumed without a result
  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 2'd0,
    OP_RESERVE = 2'd1,
    OP_COMMIT  = 2'd2,
    OP_SPARE   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_IN_PLACE  = 3'd0,
    ST_BOUNCE    = 3'd1,
    ST_FULL      = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_UNALIGNED = 3'd4,
    ST_PENDING   = 3'd5,
    ST_NO_RES    = 3'd6,
    ST_DONE      = 3'd7
  } status_e;

  typedef struct packed {
    logic [PTR_W-1:0] ring_low;
    logic [PTR_W-1:0] ring_high;
    logic             reserve_capable;
  } cfg_t;

  typedef struct packed {
    logic [PTR_W-1:0] wptr;
    logic [CNT_W-1:0] pend;
    logic             bounce;
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [PTR_W-1:0] byte_count;
    logic [PTR_W-1:0] stop_offset;
  } cmd_t;

  typedef struct packed {
    status_e          status;
    logic [PTR_W-1:0] place_offset;
    logic [CNT_W-1:0] first_chunk;
    logic [CNT_W-1:0] second_chunk;
    logic [CNT_W-1:0] reserved_publish;
    logic [PTR_W-1:0] write_offset;
  } res_t;

endpackage

// ----- rtl/crrc_if.sv -----
// valid/ready channel interfaces: command beats, result beats, register writes
// depends on crrc_pkg for field widths
`timescale 1ns / 1ps

interface crrc_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [crrc_pkg::OP_W-1:0]   opcode;
  logic [crrc_pkg::PTR_W-1:0]  byte_count;
  logic [crrc_pkg::PTR_W-1:0]  stop_offset;
  modport source (output valid, opcode, byte_count, stop_offset, input ready);
  modport sink   (input valid, opcode, byte_count, stop_offset, output ready);
endinterface

interface crrc_res_if;
  logic                        valid;
  logic                        ready;
  logic [crrc_pkg::ST_W-1:0]   status;
  logic [crrc_pkg::PTR_W-1:0]  place_offset;
  logic [crrc_pkg::CNT_W-1:0]  first_chunk;
  logic [crrc_pkg::CNT_W-1:0]  second_chunk;
  logic [crrc_pkg::CNT_W-1:0]  reserved_publish;
  logic [crrc_pkg::PTR_W-1:0]  write_offset;
  modport source (output valid, status, place_offset, first_chunk, second_chunk,
                  reserved_publish, write_offset, input ready);
  modport sink   (input valid, status, place_offset, first_chunk, second_chunk,
                  reserved_publish, write_offset, output ready);
endinterface

interface crrc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [crrc_pkg::CFG_IDX_W-1:0]   index;
  logic [crrc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/crrc_eval.sv -----
// single-pass evaluation of one command against the ring state
// depends on crrc_pkg; pure combinational, used by the top level
`timescale 1ns / 1ps

module crrc_eval (
  input  crrc_pkg::cfg_t   cfg_i,
  input  crrc_pkg::state_t state_i,
  input  crrc_pkg::cmd_t   cmd_i,
  output crrc_pkg::state_t state_o,
  output crrc_pkg::res_t   res_o
);
  import crrc_pkg::*;

  logic signed [SW-1:0] lo_s, hi_s, nx_s, sp_s, b_s;
  logic signed [SW-1:0] span_s, end_s, gap_s;
  logic                 too_large, unaligned, fits, full, wraps_back;
  logic [CNT_W-1:0]     rbytes, cbytes, first;
  logic [PTR_W-1:0]     room;
  logic [PTR_W:0]       adv, adv_wrap;

  assign lo_s = $signed({{(SW-PTR_W){1'b0}}, cfg_i.ring_low});
  assign hi_s = $signed({{(SW-PTR_W){1'b0}}, cfg_i.ring_high});
  assign nx_s = $signed({{(SW-PTR_W){1'b0}}, state_i.wptr});
  assign sp_s = $signed({{(SW-PTR_W){1'b0}}, cmd_i.stop_offset});
  assign b_s  = $signed({{(SW-PTR_W){1'b0}}, cmd_i.byte_count});

  assign span_s = hi_s - lo_s;
  assign end_s  = nx_s + b_s;
  assign gap_s  = (hi_s - nx_s) + (sp_s - lo_s);

  assign too_large = (cmd_i.byte_count > PTR_W'(BOUNCE_BYTES)) || (b_s > span_s);
  assign unaligned = |cmd_i.byte_count[1:0];
  assign rbytes    = cmd_i.byte_count[CNT_W-1:0];

  // write offset at or past the consumer: room up to the end plus from the start
  always_comb begin
    if (nx_s >= sp_s) begin
      fits = (end_s < hi_s) || ((end_s == hi_s) && (sp_s > lo_s));
      full = !fits && (gap_s <= b_s);
    end else begin
      fits = end_s < sp_s;
      full = !fits;
    end
  end

  // commit length saturates to the reservation
  assign cbytes = (cmd_i.byte_count > {{(PTR_W-CNT_W){1'b0}}, state_i.pend})
                  ? state_i.pend : cmd_i.byte_count[CNT_W-1:0];
  assign room   = (cfg_i.ring_high > state_i.wptr) ? (cfg_i.ring_high - state_i.wptr) : '0;
  assign first  = ({{(PTR_W-CNT_W){1'b0}}, cbytes} < room) ? cbytes : room[CNT_W-1:0];

  assign adv        = {1'b0, state_i.wptr} + {{(PTR_W+1-CNT_W){1'b0}}, cbytes};
  assign wraps_back = adv >= {1'b0, cfg_i.ring_high};
  assign adv_wrap   = adv - {1'b0, cfg_i.ring_high} + {1'b0, cfg_i.ring_low};

  always_comb begin
    state_o              = state_i;
    res_o.status         = ST_DONE;
    res_o.place_offset   = '0;
    res_o.first_chunk    = '0;
    res_o.second_chunk   = '0;
    res_o.reserved_publish = '0;
    unique case (op_e'(cmd_i.opcode))
      OP_INIT: begin
        state_o.wptr   = cfg_i.ring_low;
        state_o.pend   = '0;
        state_o.bounce = 1'b0;
      end
      OP_RESERVE: begin
        priority if (too_large) begin
          res_o.status = ST_TOO_LARGE;
        end else if (unaligned) begin
          res_o.status = ST_UNALIGNED;
        end else if (state_i.pend != '0) begin
          res_o.status = ST_PENDING;
        end else if (full) begin
          res_o.status = ST_FULL;
        end else if (fits && (cfg_i.reserve_capable || rbytes <= CNT_W'(4))) begin
          state_o.pend           = rbytes;
          state_o.bounce         = 1'b0;
          res_o.status           = ST_IN_PLACE;
          res_o.place_offset     = state_i.wptr;
          res_o.reserved_publish = cfg_i.reserve_capable ? rbytes : '0;
        end else begin
          state_o.pend       = rbytes;
          state_o.bounce     = 1'b1;
          res_o.status       = ST_BOUNCE;
          res_o.place_offset = state_i.wptr;
        end
      end
      OP_COMMIT: begin
        priority if (unaligned) begin
          res_o.status = ST_UNALIGNED;
        end else if (state_i.pend == '0) begin
          res_o.status = ST_NO_RES;
        end else begin
          state_o.pend       = '0;
          state_o.wptr       = wraps_back ? adv_wrap[PTR_W-1:0] : adv[PTR_W-1:0];
          res_o.place_offset = state_i.wptr;
          if (state_i.bounce) begin
            res_o.first_chunk  = first;
            res_o.second_chunk = cbytes - first;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
    res_o.write_offset = state_o.wptr;
  end

endmodule

// ----- rtl/command_ring_reserve_commit_unit.sv -----
// top level of the command ring reserve/commit unit: channels, registers, state
// depends on crrc_pkg, the interfaces in crrc_if.sv and crrc_eval
`timescale 1ns / 1ps

// Producer side of a circular command ring between ring_low and ring_high.
// Init, reserve and commit beats arrive on cmd_i; each gives one result beat
// on res_o, in order, and opcode 3 is consumed without a result. The unit
// takes one command every cycle while res_o does not stall: a command beat is
// captured in an input register, evaluated against the write pointer and
// reservation in a single pass, and the result lands in an output register.
// The state update happens in that same evaluation step, which keeps dependent
// commands correct back to back. Back-pressure on res_o holds the evaluation
// stage; cmd_i keeps taking a beat while a result waits if the input register
// is free. Register writes on cfg_i are always taken and must only arrive
// while no command is in flight.
module command_ring_reserve_commit_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  crrc_cmd_if.sink   cmd_i,
  crrc_res_if.source res_o,
  crrc_cfg_if.sink   cfg_i
);
  import crrc_pkg::*;

  cfg_t   cfg_q;
  state_t state_q, state_d;
  cmd_t   s1_cmd_q;
  logic   s1_valid_q;
  res_t   res_q, res_d;
  logic   out_valid_q;
  logic   s1_has_res, out_free, s1_adv, in_fire;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ring_low        <= RING_LOW_RST;
      cfg_q.ring_high       <= RING_HIGH_RST;
      cfg_q.reserve_capable <= 1'b1;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_RING_LOW)  cfg_q.ring_low  <= cfg_i.data[PTR_W-1:0];
      if (cfg_i.index == CFG_RING_HIGH) cfg_q.ring_high <= cfg_i.data[PTR_W-1:0];
      if (cfg_i.index == CFG_RES_CAP)   cfg_q.reserve_capable <= cfg_i.data[0];
    end
  end

  assign s1_has_res  = s1_cmd_q.opcode != OP_SPARE;
  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_adv      = s1_valid_q && (!s1_has_res || out_free);
  assign cmd_i.ready = !s1_valid_q || s1_adv;
  assign in_fire     = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      s1_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q.opcode      <= cmd_i.opcode;
      s1_cmd_q.byte_count  <= cmd_i.byte_count;
      s1_cmd_q.stop_offset <= cmd_i.stop_offset;
    end
  end

  crrc_eval u_eval (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .cmd_i   (s1_cmd_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_has_res) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_has_res) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.status           = res_q.status;
  assign res_o.place_offset     = res_q.place_offset;
  assign res_o.first_chunk      = res_q.first_chunk;
  assign res_o.second_chunk     = res_q.second_chunk;
  assign res_o.reserved_publish = res_q.reserved_publish;
  assign res_o.write_offset     = res_q.write_offset;

`ifndef NO_ASSERTIONS
  // a reservation never exceeds the bounce buffer
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pend <= CNT_W'(BOUNCE_BYTES))
    else $error("reservation larger than bounce buffer");

  // ring state only moves when the evaluation stage advances
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(state_q))
    else $error("ring state changed without a command");

  // error and full answers leave the state untouched
  a_err_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_has_res && (res_d.status == ST_FULL || res_d.status == ST_TOO_LARGE ||
      res_d.status == ST_UNALIGNED || res_d.status == ST_PENDING ||
      res_d.status == ST_NO_RES) |=> $stable(state_q))
    else $error("state changed on an error answer");

  // chunks only come with a completed commit
  a_chunk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.first_chunk != '0 || res_q.second_chunk != '0)
      |-> res_q.status == ST_DONE)
    else $error("copy chunks on a non-commit result");
`endif

endmodule

// ----- bench/tb.sv -----
// self-checking bench for command_ring_reserve_commit_unit: directed and random
// reserve/commit traffic against a cycle-free ring model, with a results scoreboard
// depends on crrc_pkg, the channel interfaces in crrc_if.sv and the unit itself
`timescale 1ns / 1ps

module tb;
  import crrc_pkg::*;

  localparam int     HOLD_CYCLES = 150;
  localparam int     CYCLE_LIMIT = 200000;
  localparam longint RING_TOP    = 4194304;

  logic clk = 1'b0;
  logic rst_n;

  crrc_cmd_if cmd_if ();
  crrc_res_if res_if ();
  crrc_cfg_if cfg_if ();

  command_ring_reserve_commit_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  always #6 clk = ~clk;

  // mirror of the ring registers and producer state
  logic [PTR_W-1:0] ring_lo = RING_LOW_RST;
  logic [PTR_W-1:0] ring_hi = RING_HIGH_RST;
  logic             res_cap = 1'b1;
  logic [PTR_W-1:0] wptr    = '0;
  logic [CNT_W-1:0] pend    = '0;
  logic             bounced = 1'b0;

  res_t expected_q[$];
  int   mismatches    = 0;
  int   beats_sent    = 0;
  int   beats_checked = 0;
  int   reg_writes    = 0;
  int   status_seen[8];
  bit   calm   = 1'b0;
  bit   steady = 1'b0;
  int   hold_asks  = 0;
  int   hold_taken = 0;
  int   hold_left  = 0;
  int   stall_left = 0;
  int   cycles     = 0;

  function automatic bit ring_step(input cmd_t c, output res_t r);
    longint lo, hi, nx, sp, b, amt, room, first, sum;
    bit     fits, full;
    lo   = longint'(ring_lo);
    hi   = longint'(ring_hi);
    nx   = longint'(wptr);
    sp   = longint'(c.stop_offset);
    b    = longint'(c.byte_count);
    fits = 1'b0;
    full = 1'b0;
    r    = '0;
    case (c.opcode)
      OP_INIT: begin
        wptr     = ring_lo;
        pend     = '0;
        bounced  = 1'b0;
        r.status = ST_DONE;
      end
      OP_RESERVE: begin
        if (b > BOUNCE_BYTES || b > hi - lo) begin
          r.status = ST_TOO_LARGE;
        end else if (c.byte_count[1:0] != 2'b00) begin
          r.status = ST_UNALIGNED;
        end else if (pend != 0) begin
          r.status = ST_PENDING;
        end else begin
          // exact signed compare, no modular wrap
          if (nx >= sp) begin
            if (nx + b < hi || (nx + b == hi && sp > lo)) fits = 1'b1;
            else if ((hi - nx) + (sp - lo) <= b) full = 1'b1;
          end else if (nx + b < sp) begin
            fits = 1'b1;
          end else begin
            full = 1'b1;
          end
          if (full) begin
            r.status = ST_FULL;
          end else begin
            pend           = c.byte_count[CNT_W-1:0];
            r.place_offset = wptr;
            if (fits && (res_cap || b <= 4)) begin
              bounced            = 1'b0;
              r.status           = ST_IN_PLACE;
              r.reserved_publish = res_cap ? pend : '0;
            end else begin
              bounced  = 1'b1;
              r.status = ST_BOUNCE;
            end
          end
        end
      end
      OP_COMMIT: begin
        if (c.byte_count[1:0] != 2'b00) begin
          r.status = ST_UNALIGNED;
        end else if (pend == 0) begin
          r.status = ST_NO_RES;
        end else begin
          amt  = (b > longint'(pend)) ? longint'(pend) : b;
          pend = '0;
          if (bounced) begin
            room           = (hi > nx) ? hi - nx : 0;
            first          = (amt < room) ? amt : room;
            r.first_chunk  = first[CNT_W-1:0];
            r.second_chunk = CNT_W'(amt - first);
          end
          r.place_offset = wptr;
          sum = nx + amt;
          if (sum >= hi) sum = sum - hi + lo;
          wptr     = sum[PTR_W-1:0];
          r.status = ST_DONE;
        end
      end
      default: return 1'b0;
    endcase
    r.write_offset = wptr;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t ns: result beat with nothing outstanding, status %0d",
                 $time, res_if.status);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("status", want.status, res_if.status);
        check_field("place_offset", want.place_offset, res_if.place_offset);
        check_field("first_chunk", want.first_chunk, res_if.first_chunk);
        check_field("second_chunk", want.second_chunk, res_if.second_chunk);
        check_field("reserved_publish", want.reserved_publish, res_if.reserved_publish);
        check_field("write_offset", want.write_offset, res_if.write_offset);
        status_seen[res_if.status]++;
        beats_checked++;
      end
    end
  end

  // result side ready: random stall bursts plus the long hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (hold_taken != hold_asks) begin
      hold_taken   <= hold_taken + 1;
      hold_left    <= HOLD_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(0, 11);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t ns: run timed out with %0d results outstanding",
               $time, expected_q.size());
      $display("** command_ring_reserve_commit_unit: FAILED **");
      $finish;
    end
  end

  task automatic issue(input logic [OP_W-1:0] op, input logic [PTR_W-1:0] count,
                       input logic [PTR_W-1:0] stop);
    cmd_t c;
    res_t r;
    if (!calm && !steady && $urandom_range(0, 5) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.opcode      <= op;
    cmd_if.byte_count  <= count;
    cmd_if.stop_offset <= stop;
    do @(posedge clk); while (!cmd_if.ready);
    c.opcode      = op;
    c.byte_count  = count;
    c.stop_offset = stop;
    if (ring_step(c, r)) begin
      expected_q.push_back(r);
      beats_sent++;
    end
  endtask

  // drain everything, then give a spare-opcode beat time to clear the pipe
  task automatic settle();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ring(input logic [PTR_W-1:0] lo, input logic [PTR_W-1:0] hi,
                          input logic cap);
    logic [CFG_IDX_W-1:0]  idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    idx = '{CFG_RING_LOW, CFG_RING_HIGH, CFG_RES_CAP};
    val = '{lo, hi, CFG_DATA_W'(cap)};
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      do @(posedge clk); while (!cfg_if.ready);
      case (idx[i])
        CFG_RING_LOW:  ring_lo = val[i];
        CFG_RING_HIGH: ring_hi = val[i];
        default:       res_cap = val[i][0];
      endcase
      reg_writes++;
    end
    cfg_if.valid <= 1'b0;
  endtask

  // reset-time ring, no init first: error checks and their order, saturation
  task automatic test_reset_ring();
    issue(OP_RESERVE, 23'd65536, 23'd0);
    issue(OP_RESERVE, 23'd4, 23'd0);
    issue(OP_COMMIT, 23'h7FFFFF, 23'd0);
    issue(OP_COMMIT, 23'd4194304, 23'h7FFFFF);
    issue(OP_RESERVE, 23'h7FFFFF, 23'h7FFFFF);
    issue(OP_RESERVE, 23'd6, 23'd0);
    issue(OP_RESERVE, 23'd8, 23'd65544);
    issue(OP_RESERVE, 23'd0, 23'd0);
    issue(OP_COMMIT, 23'd0, 23'd0);
    issue(OP_SPARE, 23'd4, 23'd4);
    issue(OP_INIT, 23'd0, 23'd0);
  endtask

  // 64-byte ring without reserve support: bounce, wrap split, exact-end fit
  task automatic test_small_ring();
    settle();
    set_ring(23'd64, 23'd128, 1'b0);
    issue(OP_INIT, 23'd0, 23'd0);
    issue(OP_RESERVE, 23'd4, 23'd64);
    issue(OP_COMMIT, 23'd4, 23'd0);
    issue(OP_RESERVE, 23'd16, 23'd64);
    issue(OP_COMMIT, 23'd16, 23'd0);
    issue(OP_RESERVE, 23'd48, 23'd80);
    issue(OP_COMMIT, 23'd48, 23'd0);
    issue(OP_RESERVE, 23'd48, 23'd116);
    issue(OP_RESERVE, 23'd68, 23'd64);
    issue(OP_RESERVE, 23'd60, 23'd68);
    issue(OP_COMMIT, 23'd40, 23'd0);
  endtask

  task automatic test_degenerate_ring();
    settle();
    set_ring(23'd100, 23'd100, 1'b1);
    issue(OP_RESERVE, 23'd0, 23'd100);
    issue(OP_RESERVE, 23'd4, 23'd100);
    settle();
    set_ring(23'h7FFFFF, 23'd0, 1'b0);
    issue(OP_INIT, 23'd0, 23'd0);
    issue(OP_RESERVE, 23'd4, 23'd0);
  endtask

  // result side holds off while commands keep coming, so the unit fills up
  task automatic test_backpressure();
    settle();
    set_ring(23'd0, 23'd4096, 1'b1);
    issue(OP_INIT, 23'd0, 23'd0);
    steady = 1'b1;
    hold_asks <= hold_asks + 1;
    for (int i = 0; i < 40; i++) begin
      if (pend == 0) issue(OP_RESERVE, PTR_W'(4 * $urandom_range(1, 64)), wptr);
      else issue(OP_COMMIT, PTR_W'(pend), 23'd0);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    longint           size, span;
    logic [PTR_W-1:0] lo, hi, cnt, stop;
    logic [OP_W-1:0]  op;
    int               made, pick;
    for (int p = 0; p < phases; p++) begin
      if (p == phases - 1) calm <= 1'b1;
      settle();
      size = 4 * $urandom_range(4, 256);
      case ($urandom_range(0, 9))
        0: begin
          lo = '0;
          hi = PTR_W'(RING_TOP);
        end
        1: begin
          hi = PTR_W'($urandom_range(0, RING_TOP));
          lo = PTR_W'($urandom_range(hi, RING_TOP));
        end
        2: begin
          hi = PTR_W'(RING_TOP);
          lo = PTR_W'(RING_TOP - size);
        end
        3: begin
          lo = PTR_W'($urandom);
          hi = PTR_W'($urandom);
        end
        default: begin
          lo = PTR_W'($urandom_range(0, RING_TOP - size));
          if ($urandom_range(0, 3) != 0) lo[1:0] = 2'b00;
          hi = lo + PTR_W'(size);
          if ($urandom_range(0, 4) == 0) hi = hi + PTR_W'($urandom_range(1, 3));
        end
      endcase
      set_ring(lo, hi, 1'($urandom_range(0, 1)));
      // sometimes keep the old write offset so it may sit outside the new ring
      if ($urandom_range(0, 3) != 0) issue(OP_INIT, PTR_W'($urandom), PTR_W'($urandom));
      made = 0;
      while (made < per_phase) begin
        size = longint'(ring_hi) - longint'(ring_lo);
        span = (size <= 0) ? 16 : ((size < BOUNCE_BYTES) ? size : BOUNCE_BYTES);
        stop = PTR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          op  = OP_INIT;
          cnt = PTR_W'($urandom);
        end else if (pick < 14) begin
          op  = OP_W'($urandom_range(0, 3));
          cnt = PTR_W'($urandom);
        end else if (pend == 0) begin
          op = OP_RESERVE;
          case ($urandom_range(0, 9))
            0:       cnt = PTR_W'(4 * $urandom_range(0, BOUNCE_BYTES / 4 + 1));
            1:       cnt = PTR_W'(4 * $urandom_range(0, span / 4) + $urandom_range(1, 3));
            2, 3:    cnt = PTR_W'(4 * $urandom_range(0, span / 4));
            default: cnt = PTR_W'(4 * $urandom_range(0, span / 16));
          endcase
          // consumer offset: empty ring, ring start, just ahead, or anywhere
          case ($urandom_range(0, 5))
            0, 1:    stop = wptr;
            2:       stop = ring_lo;
            3:       stop = wptr + PTR_W'(4 * $urandom_range(0, 64));
            default: stop = PTR_W'($urandom_range(ring_lo, ring_hi));
          endcase
        end else begin
          op = OP_COMMIT;
          case ($urandom_range(0, 9))
            0:       cnt = PTR_W'(4 * $urandom_range(0, pend / 4));
            1:       cnt = PTR_W'(pend) + PTR_W'(4 * $urandom_range(1, 16));
            2:       cnt = PTR_W'(pend) + PTR_W'($urandom_range(1, 3));
            default: cnt = PTR_W'(pend);
          endcase
        end
        issue(op, cnt, stop);
        if (op != OP_SPARE) made++;
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.opcode      = OP_INIT;
    cmd_if.byte_count  = '0;
    cmd_if.stop_offset = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_RING_LOW;
    cfg_if.data        = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_ring();
    test_small_ring();
    test_degenerate_ring();
    test_backpressure();
    test_random_traffic(8, 50);

    settle();
    repeat (4) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, expected_q.size());
      mismatches += expected_q.size();
    end
    $display("covered %0d command beats over %0d register writes, %0d results checked",
             beats_sent, reg_writes, beats_checked);
    $write("status mix: in place %0d, bounce %0d, full %0d, too large %0d, unaligned %0d,",
           status_seen[ST_IN_PLACE], status_seen[ST_BOUNCE], status_seen[ST_FULL],
           status_seen[ST_TOO_LARGE], status_seen[ST_UNALIGNED]);
    $display(" pending %0d, no reservation %0d, done %0d; %0d mismatches",
             status_seen[ST_PENDING], status_seen[ST_NO_RES], status_seen[ST_DONE],
             mismatches);
    if (mismatches == 0) begin
      $display("** command_ring_reserve_commit_unit: PASSED **");
    end else begin
      $display("** command_ring_reserve_commit_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/crrc_pkg.sv
rtl/crrc_if.sv
rtl/crrc_eval.sv
rtl/command_ring_reserve_commit_unit.sv
bench/tb.sv
